@@ hw/rtl/tbpn_pkg.sv @@
`timescale 1ns / 1ps

package tbpn_pkg;

    localparam int PAGE_W  = 4;
    localparam int CNT_W   = 4;
    localparam int TIME_W  = 32;
    localparam int HOLD_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PAGE_W-1:0] MIN_PAGE = PAGE_W'(1);

    localparam logic [CNT_W-1:0]  DEBOUNCE_RESET = CNT_W'(5);
    localparam logic [HOLD_W-1:0] EXIT_HOLD_RESET = HOLD_W'(2000);
    localparam logic [HOLD_W-1:0] ARM_HOLD_RESET  = HOLD_W'(3000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_SCANS = 2'd0,
        CFG_EXIT_HOLD_MS   = 2'd1,
        CFG_ARM_HOLD_MS    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              button_left;
        logic              button_right;
        logic              drive_lock;
    } scan_t;

    typedef struct packed {
        logic [CNT_W-1:0]  debounce_scans;
        logic [HOLD_W-1:0] exit_hold_ms;
        logic [HOLD_W-1:0] arm_hold_ms;
    } nav_cfg_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [CNT_W-1:0]  cnt_left;
        logic [CNT_W-1:0]  cnt_right;
        logic              armed;
        logic              mask;
        logic [TIME_W-1:0] hold_start;
        logic              hold_valid;
        logic              hold_consumed;
    } nav_state_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              page_load;
        logic              game_buttons_valid;
        logic              game_left;
        logic              game_right;
        logic              left_accepted;
        logic              right_accepted;
    } nav_result_t;

endpackage

@@ hw/rtl/tbpn_core.sv @@
`timescale 1ns / 1ps

module tbpn_core #(
    parameter int PAGE_COUNT = 9
) (
    input  tbpn_pkg::scan_t      scan,
    input  tbpn_pkg::nav_cfg_t   cfg,
    input  tbpn_pkg::nav_state_t cur,
    output tbpn_pkg::nav_state_t nxt,
    output tbpn_pkg::nav_result_t res
);
    import tbpn_pkg::*;

    localparam logic [PAGE_W-1:0] MAX_PAGE    = PAGE_W'(PAGE_COUNT - 3);
    localparam logic [PAGE_W-1:0] GAME_A_PAGE = PAGE_W'(PAGE_COUNT - 2);
    localparam logic [PAGE_W-1:0] GAME_B_PAGE = PAGE_W'(PAGE_COUNT - 1);

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             acc;
    } deb_t;

    // Count consecutive pressed scans; fire once when the count reaches the limit.
    function automatic deb_t debounce_step(input logic pressed,
                                           input logic [CNT_W-1:0] cnt,
                                           input logic [CNT_W-1:0] limit);
        deb_t r;
        r.cnt = cnt;
        r.acc = 1'b0;
        if (!pressed) begin
            r.cnt = '0;
        end else if (cnt < limit) begin
            r.cnt = cnt + CNT_W'(1);
            r.acc = (r.cnt >= limit);
        end
        return r;
    endfunction

    logic [TIME_W-1:0] start_eff;
    logic [TIME_W-1:0] held;
    logic              consumed_eff;
    logic              on_game;
    logic              left;
    logic              right;
    deb_t              deb_l;
    deb_t              deb_r;
    logic [PAGE_W-1:0] step_page;

    assign left         = scan.button_left;
    assign right        = scan.button_right;
    assign start_eff    = cur.hold_valid ? cur.hold_start : scan.now_ms;
    assign held         = scan.now_ms - start_eff;
    assign consumed_eff = cur.hold_valid & cur.hold_consumed;
    assign on_game      = (cur.page == GAME_A_PAGE) || (cur.page == GAME_B_PAGE);
    assign deb_l        = debounce_step(left, cur.cnt_left, cfg.debounce_scans);
    assign deb_r        = debounce_step(right, cur.cnt_right, cfg.debounce_scans);

    // Only one button can be down on the debounce path, so at most one step.
    always_comb begin
        step_page = cur.page;
        priority if (deb_l.acc) begin
            step_page = (cur.page <= MIN_PAGE) ? MAX_PAGE : cur.page - PAGE_W'(1);
        end else if (deb_r.acc) begin
            step_page = (cur.page >= MAX_PAGE) ? MIN_PAGE : cur.page + PAGE_W'(1);
        end else begin
            step_page = cur.page;
        end
    end

    always_comb begin
        nxt = cur;
        res = '0;
        if (scan.drive_lock) begin
            if (cur.page != MIN_PAGE) begin
                nxt.page      = MIN_PAGE;
                res.page_load = 1'b1;
            end
        end else begin
            if (!left && !right) begin
                nxt.mask = 1'b0;
            end
            if (left && right) begin
                nxt.hold_valid    = 1'b1;
                nxt.hold_start    = start_eff;
                nxt.hold_consumed = consumed_eff;
                if (!consumed_eff) begin
                    if (on_game) begin
                        if (held >= TIME_W'(cfg.exit_hold_ms)) begin
                            nxt.hold_consumed = 1'b1;
                            nxt.page          = MIN_PAGE;
                            res.page_load     = 1'b1;
                        end
                    end else if (held >= TIME_W'(cfg.arm_hold_ms)) begin
                        nxt.hold_consumed = 1'b1;
                        nxt.armed         = 1'b1;
                    end
                end
            end else begin
                nxt.armed         = 1'b0;
                nxt.hold_valid    = 1'b0;
                nxt.hold_start    = '0;
                nxt.hold_consumed = 1'b0;
                if (cur.armed && (left != right)) begin
                    // Button released first picks the game
                    nxt.mask      = 1'b1;
                    nxt.page      = left ? GAME_A_PAGE : GAME_B_PAGE;
                    res.page_load = 1'b1;
                end else if (on_game) begin
                    res.game_buttons_valid = 1'b1;
                    res.game_left          = left & ~nxt.mask;
                    res.game_right         = right & ~nxt.mask;
                end else begin
                    nxt.cnt_left       = deb_l.cnt;
                    nxt.cnt_right      = deb_r.cnt;
                    res.left_accepted  = deb_l.acc;
                    res.right_accepted = deb_r.acc;
                    if (deb_l.acc || deb_r.acc) begin
                        nxt.page      = step_page;
                        res.page_load = 1'b1;
                    end
                end
            end
        end
        res.page = nxt.page;
    end

endmodule

@@ hw/rtl/two_button_page_navigator.sv @@
`timescale 1ns / 1ps

// Two-button page navigator. Each transfer on the s_ side is one button scan
// (timestamp, two button levels, drive-lock flag) and yields exactly one
// transfer on the m_ side with the page after the scan, a page-load flag,
// the buttons forwarded to a game page, and press-acceptance pulses. The
// block takes one scan per clock while m_ready keeps the output moving: a
// scan is captured in an input register, the navigation update runs
// combinationally against the page, debounce and hold state, and the result
// lands in an output register that drives m_valid. Configuration writes on
// cfg_wr_en take effect at once and are meant for when no scan is in flight.
module two_button_page_navigator #(
    parameter int PAGE_COUNT = 9
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tbpn_pkg::TIME_W-1:0]         s_now_ms,
    input  logic                                s_button_left,
    input  logic                                s_button_right,
    input  logic                                s_drive_lock,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tbpn_pkg::PAGE_W-1:0]         m_page,
    output logic                                m_page_load,
    output logic                                m_game_buttons_valid,
    output logic                                m_game_left,
    output logic                                m_game_right,
    output logic                                m_left_accepted,
    output logic                                m_right_accepted,

    input  logic                                cfg_wr_en,
    input  logic [tbpn_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [tbpn_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import tbpn_pkg::*;

    scan_t       scan_reg;
    logic        in_valid_reg;
    nav_state_t  state_reg;
    nav_state_t  state_next;
    nav_cfg_t    cfg_reg;
    nav_result_t out_reg;
    nav_result_t result_next;
    logic        out_valid_reg;
    logic        advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    tbpn_core #(
        .PAGE_COUNT(PAGE_COUNT)
    ) u_core (
        .scan(scan_reg),
        .cfg (cfg_reg),
        .cur (state_reg),
        .nxt (state_next),
        .res (result_next)
    );

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            scan_reg.now_ms       <= s_now_ms;
            scan_reg.button_left  <= s_button_left;
            scan_reg.button_right <= s_button_right;
            scan_reg.drive_lock   <= s_drive_lock;
        end
        if (advance) begin
            out_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            cfg_reg.debounce_scans <= DEBOUNCE_RESET;
            cfg_reg.exit_hold_ms   <= EXIT_HOLD_RESET;
            cfg_reg.arm_hold_ms    <= ARM_HOLD_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_DEBOUNCE_SCANS: cfg_reg.debounce_scans <= cfg_wdata[CNT_W-1:0];
                    CFG_EXIT_HOLD_MS:   cfg_reg.exit_hold_ms   <= cfg_wdata;
                    CFG_ARM_HOLD_MS:    cfg_reg.arm_hold_ms    <= cfg_wdata;
                    default: ;  // drop writes to unused indexes
                endcase
            end
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_page               = out_reg.page;
    assign m_page_load          = out_reg.page_load;
    assign m_game_buttons_valid = out_reg.game_buttons_valid;
    assign m_game_left          = out_reg.game_left;
    assign m_game_right         = out_reg.game_right;
    assign m_left_accepted      = out_reg.left_accepted;
    assign m_right_accepted     = out_reg.right_accepted;

endmodule

@@ hw/rtl/tbpn_checker.sv @@
`timescale 1ns / 1ps

module tbpn_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [tbpn_pkg::TIME_W-1:0]     s_now_ms,
    input logic                            s_button_left,
    input logic                            s_button_right,
    input logic                            s_drive_lock,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [tbpn_pkg::PAGE_W-1:0]     m_page,
    input logic                            m_page_load,
    input logic                            m_game_buttons_valid,
    input logic                            m_game_left,
    input logic                            m_game_right,
    input logic                            m_left_accepted,
    input logic                            m_right_accepted,
    input logic                            cfg_wr_en,
    input logic [tbpn_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input logic [tbpn_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_page) && $stable(m_page_load))
        else $error("result changed while stalled");

    a_fwd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_game_buttons_valid |-> !m_game_left && !m_game_right)
        else $error("game buttons set without forward");

    a_one_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_left_accepted && m_right_accepted))
        else $error("both presses accepted in one scan");

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_left_accepted || m_right_accepted) |-> m_page_load
            && !m_game_buttons_valid)
        else $error("accepted press without page load");

    a_fwd_no_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_game_buttons_valid |-> !m_page_load)
        else $error("page load while forwarding to game");

endmodule

bind two_button_page_navigator tbpn_checker u_tbpn_checker (.*);

@@ verif/tb_two_button_page_navigator.sv @@
`timescale 1ns / 1ps

module tb_two_button_page_navigator;

    import tbpn_pkg::*;

    localparam int PAGE_COUNT  = 9;
    localparam int CYCLE_LIMIT = 400_000;

    localparam logic [PAGE_W-1:0] GAME_A_PAGE   = PAGE_W'(PAGE_COUNT - 2);
    localparam logic [PAGE_W-1:0] GAME_B_PAGE   = PAGE_W'(PAGE_COUNT - 1);
    localparam int                LAST_NAV_PAGE = PAGE_COUNT - 3;

    // index with no register behind it; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [TIME_W-1:0]     s_now_ms;
    logic                  s_button_left;
    logic                  s_button_right;
    logic                  s_drive_lock;
    logic                  m_valid;
    logic                  m_ready;
    logic [PAGE_W-1:0]     m_page;
    logic                  m_page_load;
    logic                  m_game_buttons_valid;
    logic                  m_game_left;
    logic                  m_game_right;
    logic                  m_left_accepted;
    logic                  m_right_accepted;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    two_button_page_navigator #(
        .PAGE_COUNT(PAGE_COUNT)
    ) u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_now_ms            (s_now_ms),
        .s_button_left       (s_button_left),
        .s_button_right      (s_button_right),
        .s_drive_lock        (s_drive_lock),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_page              (m_page),
        .m_page_load         (m_page_load),
        .m_game_buttons_valid(m_game_buttons_valid),
        .m_game_left         (m_game_left),
        .m_game_right        (m_game_right),
        .m_left_accepted     (m_left_accepted),
        .m_right_accepted    (m_right_accepted),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_addr            (cfg_addr),
        .cfg_wdata           (cfg_wdata)
    );

    // navigator state as the testbench tracks it
    logic [PAGE_W-1:0] nav_page;
    logic [CNT_W-1:0]  press_cnt [2];
    logic              sel_armed;
    logic              mask_held;
    logic [TIME_W-1:0] hold_t0;
    logic              hold_active;
    logic              hold_used;
    logic [CNT_W-1:0]  cfg_debounce;
    logic [HOLD_W-1:0] cfg_exit;
    logic [HOLD_W-1:0] cfg_arm;

    nav_result_t       expected_screens [$];
    logic [TIME_W-1:0] nav_clock_ms;
    int                scans_sent;
    int                mismatches;
    int                cycle_count;
    int                rx_stall_cycles;
    bit                no_idle;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic bit is_game_page(input logic [PAGE_W-1:0] p);
        return p == GAME_A_PAGE || p == GAME_B_PAGE;
    endfunction

    // advance the tracked state by one scan and return what the block should report
    function automatic nav_result_t predict_scan(input logic [TIME_W-1:0] now, input logic l,
                                                 input logic r, input logic lock);
        nav_result_t       res;
        logic [TIME_W-1:0] held;
        logic              lv [2];
        bit                picked;
        int                nxt;
        int                i;
        res    = '0;
        lv[0]  = l;
        lv[1]  = r;
        picked = 1'b0;
        if (lock) begin
            if (nav_page != MIN_PAGE) begin
                nav_page      = MIN_PAGE;
                res.page_load = 1'b1;
            end
        end else if (l && r) begin
            if (!hold_active) begin
                hold_active = 1'b1;
                hold_t0     = now;
                hold_used   = 1'b0;
            end
            if (!hold_used) begin
                held = now - hold_t0;
                if (is_game_page(nav_page)) begin
                    if (held >= TIME_W'(cfg_exit)) begin
                        hold_used     = 1'b1;
                        nav_page      = MIN_PAGE;
                        res.page_load = 1'b1;
                    end
                end else if (held >= TIME_W'(cfg_arm)) begin
                    hold_used = 1'b1;
                    sel_armed = 1'b1;
                end
            end
        end else begin
            if (!l && !r) mask_held = 1'b0;
            if (sel_armed) begin
                sel_armed = 1'b0;
                // one button released first picks the game, both together disarm
                if (l != r) begin
                    mask_held     = 1'b1;
                    hold_active   = 1'b0;
                    hold_t0       = '0;
                    hold_used     = 1'b0;
                    nav_page      = l ? GAME_A_PAGE : GAME_B_PAGE;
                    res.page_load = 1'b1;
                    picked        = 1'b1;
                end
            end
            if (!picked) begin
                hold_active = 1'b0;
                hold_t0     = '0;
                hold_used   = 1'b0;
                if (is_game_page(nav_page)) begin
                    res.game_buttons_valid = 1'b1;
                    res.game_left          = l && !mask_held;
                    res.game_right         = r && !mask_held;
                end else begin
                    for (i = 0; i < 2; i++) begin
                        if (!lv[i]) begin
                            press_cnt[i] = '0;
                        end else if (press_cnt[i] < cfg_debounce) begin
                            press_cnt[i] = press_cnt[i] + CNT_W'(1);
                            if (press_cnt[i] >= cfg_debounce) begin
                                if (i == 0) begin
                                    res.left_accepted = 1'b1;
                                    nxt = (nav_page <= MIN_PAGE) ? LAST_NAV_PAGE
                                                                 : int'(nav_page) - 1;
                                end else begin
                                    res.right_accepted = 1'b1;
                                    nxt = int'(nav_page) + 1;
                                end
                                if (nxt > LAST_NAV_PAGE) nxt = int'(MIN_PAGE);
                                nav_page      = PAGE_W'(nxt);
                                res.page_load = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        res.page = nav_page;
        return res;
    endfunction

    task automatic send_scan(input logic [TIME_W-1:0] now, input logic l, input logic r,
                             input logic lock);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_now_ms       <= now;
        s_button_left  <= l;
        s_button_right <= r;
        s_drive_lock   <= lock;
        expected_screens.push_back(predict_scan(now, l, r, lock));
        nav_clock_ms = now;
        scans_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic step_scan(input int dt, input logic l, input logic r, input logic lock);
        send_scan(nav_clock_ms + TIME_W'(dt), l, r, lock);
    endtask

    // drop valid and let every scan in flight come out
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_screens.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_DEBOUNCE_SCANS: cfg_debounce = data[CNT_W-1:0];
            CFG_EXIT_HOLD_MS:   cfg_exit     = data[HOLD_W-1:0];
            CFG_ARM_HOLD_MS:    cfg_arm      = data[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] deb, input logic [CFG_DATA_W-1:0] ex,
                                  input logic [CFG_DATA_W-1:0] arm);
        wait_drained();
        write_reg(CFG_DEBOUNCE_SCANS, deb);
        write_reg(CFG_EXIT_HOLD_MS, ex);
        write_reg(CFG_ARM_HOLD_MS, arm);
    endtask

    task automatic random_gesture();
        int          kind;
        int          n;
        int          b;
        logic [15:0] thr;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: begin
                // single press, sometimes too short to pass the debounce
                b = $urandom_range(0, 1);
                n = $urandom_range(1, int'(cfg_debounce) + 3);
                repeat (n) step_scan($urandom_range(1, 40), b == 0, b == 1, 1'b0);
                repeat ($urandom_range(1, 2)) step_scan($urandom_range(1, 40), 1'b0, 1'b0, 1'b0);
            end
            4, 5, 6: begin
                thr = is_game_page(nav_page) ? cfg_exit : cfg_arm;
                n = $urandom_range(2, 6);
                repeat (n) step_scan($urandom_range(0, int'(thr) / 2 + 1), 1'b1, 1'b1, 1'b0);
                case ($urandom_range(0, 3))
                    0: step_scan($urandom_range(1, 40), 1'b0, 1'b0, 1'b0);
                    1: begin
                        step_scan($urandom_range(1, 40), 1'b0, 1'b1, 1'b0);
                        step_scan($urandom_range(1, 40), 1'b0, 1'b1, 1'b0);
                        step_scan($urandom_range(1, 40), 1'b0, 1'b0, 1'b0);
                    end
                    2: begin
                        step_scan($urandom_range(1, 40), 1'b1, 1'b0, 1'b0);
                        step_scan($urandom_range(1, 40), 1'b0, 1'b0, 1'b0);
                    end
                    default: step_scan($urandom_range(1, 40), 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1)), 1'b1);
                endcase
            end
            7: begin
                repeat ($urandom_range(1, 3))
                    step_scan($urandom_range(0, 100), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'b1);
            end
            8: send_scan($urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 3) == 0);
            default: begin
                repeat ($urandom_range(1, 5)) begin
                    b = $urandom_range(0, 2);
                    step_scan($urandom_range(1, 40), b == 1, b == 2, 1'b0);
                end
            end
        endcase
    endtask

    task automatic run_random_phase(input int n_items);
        int target;
        target = scans_sent + n_items;
        while (scans_sent < target) random_gesture();
    endtask

    task automatic test_directed_gestures();
        send_scan(32'd0, 1'b0, 1'b0, 1'b0);
        // step up out of the splash page
        repeat (5) step_scan(1, 1'b0, 1'b1, 1'b0);
        step_scan(1, 1'b0, 1'b0, 1'b0);
        // hold that starts at time zero, arm, release left first
        send_scan(32'd0, 1'b1, 1'b1, 1'b0);
        send_scan(32'd3000, 1'b1, 1'b1, 1'b0);
        step_scan(10, 1'b0, 1'b1, 1'b0);
        step_scan(10, 1'b0, 1'b1, 1'b0);
        step_scan(10, 1'b0, 1'b0, 1'b0);
        step_scan(10, 1'b1, 1'b0, 1'b0);
        // exit hold across the 32-bit wrap, exactly at the threshold
        send_scan(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
        send_scan(32'h0000_07CF, 1'b1, 1'b1, 1'b0);
        step_scan(10, 1'b1, 1'b1, 1'b0);
        step_scan(10, 1'b0, 1'b0, 1'b0);
        // arm, release right first, then lock out of the game
        send_scan(32'd5000, 1'b1, 1'b1, 1'b0);
        send_scan(32'd8000, 1'b1, 1'b1, 1'b0);
        step_scan(10, 1'b1, 1'b0, 1'b0);
        step_scan(10, 1'b0, 1'b0, 1'b1);
        // lock on page 1 mid gesture, then release both together
        send_scan(32'd9000, 1'b1, 1'b1, 1'b0);
        send_scan(32'd12000, 1'b1, 1'b1, 1'b0);
        step_scan(10, 1'b1, 1'b1, 1'b1);
        step_scan(10, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_zero_debounce();
        apply_settings(16'd0, EXIT_HOLD_RESET, ARM_HOLD_RESET);
        write_reg(CFG_UNUSED_IDX, 16'hFFFF);
        repeat (4) step_scan(5, 1'b0, 1'b1, 1'b0);
        step_scan(5, 1'b0, 1'b0, 1'b0);
        repeat (3) step_scan(5, 1'b1, 1'b0, 1'b0);
    endtask

    // receiver stalls long while scans keep coming back to back
    task automatic test_output_backpressure();
        apply_settings(16'd2, EXIT_HOLD_RESET, ARM_HOLD_RESET);
        no_idle = 1'b1;
        rx_stall_cycles = 80;
        repeat (40) step_scan($urandom_range(1, 30), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
        no_idle = 1'b0;
    endtask

    task automatic test_random_settings();
        apply_settings(DEBOUNCE_RESET, EXIT_HOLD_RESET, ARM_HOLD_RESET);
        run_random_phase(100);
        apply_settings(16'd1, 16'd0, 16'd0);
        run_random_phase(100);
        apply_settings(16'd15, 16'hFFFF, 16'hFFFF);
        run_random_phase(100);
        // junk in the upper bits of the debounce write
        apply_settings(16'($urandom()), 16'($urandom_range(0, 4000)),
                       16'($urandom_range(0, 6000)));
        run_random_phase(100);
        apply_settings(16'($urandom_range(1, 6)), 16'($urandom_range(0, 3000)),
                       16'($urandom_range(0, 3000)));
        no_idle = 1'b1;
        run_random_phase(100);
        no_idle = 1'b0;
        apply_settings(16'($urandom_range(1, 15)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)));
        run_random_phase(100);
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_now_ms       = '0;
        s_button_left  = 1'b0;
        s_button_right = 1'b0;
        s_drive_lock   = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        no_idle        = 1'b0;
        rx_stall_cycles = 0;
        scans_sent     = 0;
        mismatches     = 0;
        nav_clock_ms   = '0;
        nav_page       = '0;
        press_cnt[0]   = '0;
        press_cnt[1]   = '0;
        sel_armed      = 1'b0;
        mask_held      = 1'b0;
        hold_t0        = '0;
        hold_active    = 1'b0;
        hold_used      = 1'b0;
        cfg_debounce   = DEBOUNCE_RESET;
        cfg_exit       = EXIT_HOLD_RESET;
        cfg_arm        = ARM_HOLD_RESET;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_gestures();
        test_zero_debounce();
        test_output_backpressure();
        test_random_settings();

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // result side: random hold-off per transfer, plus long stalls on request
    initial begin : rx_proc
        int w;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            w = rx_stall_cycles + (no_idle ? 0 : $urandom_range(0, 7));
            rx_stall_cycles = 0;
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        nav_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_screens.size() == 0) begin
                $display("%0t: unexpected result, expected none, got page %0d", $time, m_page);
                mismatches++;
            end else begin
                want = expected_screens.pop_front();
                check_field("page", int'(want.page), int'(m_page));
                check_field("page_load", int'(want.page_load), int'(m_page_load));
                check_field("game_buttons_valid", int'(want.game_buttons_valid),
                            int'(m_game_buttons_valid));
                check_field("game_left", int'(want.game_left), int'(m_game_left));
                check_field("game_right", int'(want.game_right), int'(m_game_right));
                check_field("left_accepted", int'(want.left_accepted), int'(m_left_accepted));
                check_field("right_accepted", int'(want.right_accepted),
                            int'(m_right_accepted));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial cycle_count = 0;

endmodule
